// ----- hw/rtl/dsd_pkg.sv -----
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants for the deauthentication storm detector.
// ----------------------------------------------------------------------------
package dsd_pkg;

   // counter width default for the top-level parameter
   localparam int DSD_COUNT_BITS = 16;

   // management frame subtypes that count toward a window
   localparam logic [3:0] SUBTYPE_DEAUTH   = 4'hC;
   localparam logic [3:0] SUBTYPE_DISASSOC = 4'hA;
   localparam logic [7:0] SUBTYPE_MASK     = 8'h0F;

   // register reset values
   localparam logic [15:0] WINDOW_TICKS_RST = 16'd1000;
   localparam logic [15:0] STORM_ON_RST     = 16'd10;
   localparam logic [15:0] STORM_OFF_RST    = 16'd3;

   // register indexes
   typedef enum logic [1:0] {
      CSR_WINDOW_TICKS = 2'd0,
      CSR_STORM_ON     = 2'd1,
      CSR_STORM_OFF    = 2'd2
   } csr_index_type;

   // item modes
   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // one input item
   typedef struct packed {
      logic        mode;
      logic        is_management;
      logic [7:0]  frame_control;
      logic [47:0] transmitter_addr;
   } req_type;

   // one result item
   typedef struct packed {
      logic        storm_active;
      logic        storm_started;
      logic        window_closed;
      logic [15:0] deauth_rate;
      logic [15:0] deauth_peak;
      logic [47:0] storm_source;
   } rsp_type;

   // configuration seen by the window core
   typedef struct packed {
      logic [15:0] window_ticks;
      logic [15:0] storm_on_threshold;
      logic [15:0] storm_off_threshold;
   } cfg_type;

endpackage

// ----- hw/rtl/dsd_in_stage.sv -----
// ----------------------------------------------------------------------------
// dsd_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module dsd_in_stage
   import dsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // the register frees up when empty or when its item moves on
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload load on input transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// ----- hw/rtl/dsd_window_core.sv -----
// ----------------------------------------------------------------------------
// dsd_window_core
// Window state and single-pass update: frame counting, tick timing,
// window close with storm hysteresis and peak tracking.
// ----------------------------------------------------------------------------
module dsd_window_core
   import dsd_pkg::*;
#(
   parameter int COUNT_BITS = DSD_COUNT_BITS
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic [15:0]           elapsed_ff, elapsed_in;
   logic                  flag_ff, flag_in;
   logic [47:0]           source_ff, source_in;

   logic [3:0]            subtype;
   logic                  frame_hit;
   logic                  is_tick;
   logic [15:0]           elapsed_inc;
   logic                  close;
   logic                  start;
   logic [CMP_W-1:0]      count_ext;
   logic [CMP_W-1:0]      rate_ext;
   logic [CMP_W-1:0]      peak_ext;

   // frame classification
   assign subtype   = 4'((item.frame_control >> 4) & SUBTYPE_MASK);
   assign is_tick   = (item.mode == MODE_TICK);
   assign frame_hit = !is_tick && item.is_management &&
                      (subtype inside {SUBTYPE_DEAUTH, SUBTYPE_DISASSOC});

   // tick timing with saturation
   assign elapsed_inc = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign close       = is_tick && (elapsed_inc >= cfg.window_ticks);
   assign count_ext   = CMP_W'(count_ff);

   // storm start and end tests at window close
   assign start = close && !flag_ff && (count_ext >= CMP_W'(cfg.storm_on_threshold));

   always_comb begin
      flag_in = flag_ff;
      if (close) begin
         if (count_ext < CMP_W'(cfg.storm_off_threshold)) begin
            flag_in = 1'b0;
         end else begin
            flag_in = flag_ff | start;
         end
      end
   end

   // peak, count, timer and source next values
   assign peak_in = (close && (count_ff > peak_ff)) ? count_ff : peak_ff;

   always_comb begin
      count_in = count_ff;
      if (frame_hit) begin
         if (count_ff != {COUNT_BITS{1'b1}}) begin
            count_in = count_ff + 1'b1;
         end
      end else if (close) begin
         count_in = '0;
      end
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      if (is_tick) begin
         elapsed_in = close ? 16'd0 : elapsed_inc;
      end
   end

   assign source_in = frame_hit ? item.transmitter_addr : source_ff;

   // state registers, updated once per consumed item
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         peak_ff    <= '0;
         elapsed_ff <= '0;
         flag_ff    <= 1'b0;
         source_ff  <= '0;
      end else if (fire) begin
         count_ff   <= count_in;
         peak_ff    <= peak_in;
         elapsed_ff <= elapsed_in;
         flag_ff    <= flag_in;
         source_ff  <= source_in;
      end
   end

   // result after this step
   assign rate_ext = CMP_W'(count_in);
   assign peak_ext = CMP_W'(peak_in);

   always_comb begin
      result.storm_active  = flag_in;
      result.storm_started = start;
      result.window_closed = close;
      result.deauth_rate   = rate_ext[15:0];
      result.deauth_peak   = peak_ext[15:0];
      result.storm_source  = source_in;
   end

   // a closing tick leaves an empty window and a restarted timer
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      fire && close |=> count_ff == '0 && elapsed_ff == 16'd0)
      else $error("window state not cleared after close");

   // the peak never falls
   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> peak_ff >= $past(peak_ff))
      else $error("peak count decreased");

   // without a consumed item the state holds
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff) && $stable(flag_ff) && $stable(elapsed_ff))
      else $error("window state changed without an item");

   // the storm flag only rises at a window close
   a_flag_rise_on_close: assert property (@(posedge clock) disable iff (reset)
      !flag_ff && !(fire && close) |=> !flag_ff)
      else $error("storm flag set outside a window close");

endmodule

// ----- hw/rtl/dsd_out_stage.sv -----
// ----------------------------------------------------------------------------
// dsd_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module dsd_out_stage
   import dsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type result,
   output logic    advance,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // room for a new result when empty or when the held one transfers
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result load
   always_ff @(posedge clock) begin
      if (load && advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// ----- hw/rtl/deauth_storm_detector.sv -----
// ----------------------------------------------------------------------------
// deauth_storm_detector
// Counts deauthentication and disassociation frames per tick window and
// flags storms with on/off hysteresis.
// ----------------------------------------------------------------------------
// Each request is either a captured frame or a one-millisecond tick and
// yields exactly one response. The block takes one request per clock cycle
// while responses are taken. Each request passes through the input register
// and then through one pass of the window update logic into the response
// register. While a response waits untaken both registers hold,
// so one more request fills the input register and then req_ready follows
// rsp_ready until the held response transfers. The counter
// width COUNT_BITS sets the saturation point of the window and peak counts;
// the rate and peak fields report their low 16 bits. Registers are written
// through the csr port, always ready, and should only change while no
// request is in flight.
module deauth_storm_detector
   import dsd_pkg::*;
#(
   parameter int COUNT_BITS = DSD_COUNT_BITS
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    advance;
   logic    item_valid;
   logic    fire;
   req_type item;
   rsp_type result;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_TICKS: cfg_in.window_ticks        = csr_wdata;
            CSR_STORM_ON:     cfg_in.storm_on_threshold  = csr_wdata;
            CSR_STORM_OFF:    cfg_in.storm_off_threshold = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks        <= WINDOW_TICKS_RST;
         cfg_ff.storm_on_threshold  <= STORM_ON_RST;
         cfg_ff.storm_off_threshold <= STORM_OFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // item moves from input register into the response register
   assign fire = item_valid && advance;

   dsd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   dsd_window_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_window_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   dsd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (item_valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
